// File: hw/rtl/mtfbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfbl_pkg
// Shared types for the move-to-front/back list: request codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mtfbl_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 8;
    localparam int ELEM_W = 5;
    localparam int CNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_FRONT   = 2'd0,
        FN_BACK    = 2'd1,
        FN_READ    = 2'd2,
        FN_RESTART = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic func_read;
        logic read_last;
    } t_sts;

endpackage

// File: hw/rtl/move_to_front_back_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_back_list_core
// A move or restart is latched on accept and run in ST_EXEC once the output
// slot is free; its status is then registered. Read-out gives one entry per
// cycle out of the cell row unless stalled; no request is taken until done.
// Reset: synchronous, active low; list is 1..SIZE, length min(16, SIZE),
// count register 16.
// ----------------------------------------------------------------------------
module move_to_front_back_list_core #(
    parameter int SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mtfbl_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mtfbl_pkg::FUNC_W-1:0]  i_func,
    input  logic [mtfbl_pkg::ID_W-1:0]    i_element_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mtfbl_pkg::ELEM_W-1:0]  o_element,
    output logic                          o_last,
    output logic                          o_status
);

    mtfbl_pkg::t_cmd w_cmd;
    mtfbl_pkg::t_sts w_sts;

    mtfbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mtfbl_dpath #(
        .SIZE (SIZE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_element_id (i_element_id),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_element    (o_element),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.exec && w_cmd.emit))
        else $error("exec and emit issued together");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.exec || w_cmd.emit) |-> w_sts.out_free)
        else $error("result loaded into an occupied output slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still running");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> (o_out_valid && o_last && (o_element == '0)))
        else $error("move or restart result malformed");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_sts.read_last) |=> (o_out_valid && o_last))
        else $error("final read-out entry not marked last");

endmodule

// File: hw/rtl/mtfbl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfbl_ctrl
// Sequencer: takes one request, runs the list update or steps the read-out
// one entry per free output slot, then returns to idle.
// ----------------------------------------------------------------------------
module mtfbl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mtfbl_pkg::t_sts i_sts,
    output mtfbl_pkg::t_cmd o_cmd
);

    mtfbl_pkg::t_state r_state;
    mtfbl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtfbl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mtfbl_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = mtfbl_pkg::ST_EXEC;
                end
            end
            mtfbl_pkg::ST_EXEC: begin
                if (i_sts.out_free) begin
                    if (i_sts.func_read) begin
                        o_cmd.emit = 1'b1;
                        n_state    = i_sts.read_last ? mtfbl_pkg::ST_IDLE
                                                     : mtfbl_pkg::ST_READ;
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_state    = mtfbl_pkg::ST_IDLE;
                    end
                end
            end
            mtfbl_pkg::ST_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.read_last) begin
                        n_state = mtfbl_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mtfbl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/mtfbl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfbl_dpath
// Row of list cells with parallel compare against the request identifier,
// a shift for front/back moves, restart refill, read-out index and
// the output register.
// ----------------------------------------------------------------------------
module mtfbl_dpath #(
    parameter int SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mtfbl_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic [mtfbl_pkg::FUNC_W-1:0]  i_func,
    input  logic [mtfbl_pkg::ID_W-1:0]    i_element_id,
    input  mtfbl_pkg::t_cmd               i_cmd,
    output mtfbl_pkg::t_sts               o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mtfbl_pkg::ELEM_W-1:0]  o_element,
    output logic                          o_last,
    output logic                          o_status
);

    localparam int EW      = $clog2(SIZE + 1);
    localparam int IW      = $clog2(SIZE);
    localparam int LW      = EW;
    localparam int LEN_RST = (SIZE < 16) ? SIZE : 16;
    localparam int ID_EXT  = mtfbl_pkg::ID_W;

    logic [EW-1:0]                  r_order [SIZE];
    logic [EW-1:0]                  n_order [SIZE];
    logic [EW-1:0]                  w_prev  [SIZE];
    logic [EW-1:0]                  w_next  [SIZE];
    logic [LW-1:0]                  r_len;
    logic [LW-1:0]                  n_len;
    logic [mtfbl_pkg::CNT_W-1:0]    r_active;
    mtfbl_pkg::t_func               r_func;
    logic [mtfbl_pkg::ID_W-1:0]     r_id;
    logic [IW-1:0]                  r_idx;
    logic                           r_out_valid;
    logic [mtfbl_pkg::ELEM_W-1:0]   r_out_element;
    logic                           r_out_last;
    logic                           r_out_status;

    logic [SIZE-1:0]                w_hit;
    logic [IW-1:0]                  w_pos;
    logic                           w_found;
    logic [IW-1:0]                  w_tail;
    logic [LW-1:0]                  w_len_m1;
    logic [LW-1:0]                  w_count;

    assign w_len_m1 = r_len - LW'(1);
    assign w_tail   = w_len_m1[IW-1:0];

    genvar g;
    generate
        for (g = 0; g < SIZE; g++) begin : g_cell
            assign w_hit[g] = (ID_EXT'(r_order[g]) == r_id) && (LW'(g) < r_len);
            if (g == 0) begin : g_first
                assign w_prev[g] = r_id[EW-1:0];
            end else begin : g_mid_p
                assign w_prev[g] = r_order[g-1];
            end
            if (g == SIZE - 1) begin : g_lastc
                assign w_next[g] = r_id[EW-1:0];
            end else begin : g_mid_n
                assign w_next[g] = r_order[g+1];
            end
        end
    endgenerate

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < SIZE; i++) begin
            if (w_hit[i]) begin
                w_pos = w_pos | IW'(i);
            end
        end
    end

    assign w_found = |w_hit;

    always_comb begin
        if (r_active == '0) begin
            w_count = LW'(1);
        end else if (32'(r_active) > SIZE) begin
            w_count = LW'(SIZE);
        end else begin
            w_count = LW'(r_active);
        end
    end

    always_comb begin
        n_len = r_len;
        for (int i = 0; i < SIZE; i++) begin
            n_order[i] = r_order[i];
        end
        if (i_cmd.exec) begin
            case (r_func)
                mtfbl_pkg::FN_FRONT: begin
                    if (w_found) begin
                        for (int i = 0; i < SIZE; i++) begin
                            if (IW'(i) <= w_pos) begin
                                n_order[i] = w_prev[i];
                            end
                        end
                    end
                end
                mtfbl_pkg::FN_BACK: begin
                    if (w_found) begin
                        for (int i = 0; i < SIZE; i++) begin
                            if (IW'(i) == w_tail) begin
                                n_order[i] = r_id[EW-1:0];
                            end else if (IW'(i) >= w_pos && IW'(i) < w_tail) begin
                                n_order[i] = w_next[i];
                            end
                        end
                    end
                end
                mtfbl_pkg::FN_RESTART: begin
                    for (int i = 0; i < SIZE; i++) begin
                        n_order[i] = EW'(i + 1);
                    end
                    n_len = w_count;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIZE; i++) begin
                r_order[i] <= EW'(i + 1);
            end
            r_len    <= LW'(LEN_RST);
            r_active <= mtfbl_pkg::CNT_W'(16);
        end else begin
            for (int i = 0; i < SIZE; i++) begin
                r_order[i] <= n_order[i];
            end
            r_len <= n_len;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= mtfbl_pkg::t_func'(i_func);
            r_id   <= i_element_id;
            r_idx  <= '0;
        end else if (i_cmd.emit) begin
            r_idx  <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_element <= '0;
            r_out_last    <= 1'b1;
            r_out_status  <= (r_func != mtfbl_pkg::FN_RESTART) && !w_found;
        end else if (i_cmd.emit) begin
            r_out_element <= mtfbl_pkg::ELEM_W'(r_order[r_idx]);
            r_out_last    <= (r_idx == w_tail);
            r_out_status  <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.func_read = (r_func == mtfbl_pkg::FN_READ);
    assign o_sts.read_last = (r_idx == w_tail);

    assign o_out_valid = r_out_valid;
    assign o_element   = r_out_element;
    assign o_last      = r_out_last;
    assign o_status    = r_out_status;

endmodule

// File: bench/move_to_front_back_list_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_back_list_chk
// Watches the request and result channels of the list core. Keeps its own
// copy of the list order, its length and the count register, predicts the
// results of every accepted request, and compares each accepted result field
// by field against the oldest prediction. Reports the failure count and the
// number of predictions still open.
// ----------------------------------------------------------------------------
module move_to_front_back_list_chk #(
    parameter int SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mtfbl_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [mtfbl_pkg::FUNC_W-1:0]  i_func,
    input  logic [mtfbl_pkg::ID_W-1:0]    i_element_id,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [mtfbl_pkg::ELEM_W-1:0]  i_element,
    input  logic                          i_last,
    input  logic                          i_status,
    output int                            o_fail_count,
    output int                            o_pending
);
    import mtfbl_pkg::*;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              status;
    } t_list_result;

    logic [ELEM_W-1:0] list_order [SIZE];
    int                list_len;
    logic [CNT_W-1:0]  count_reg;
    t_list_result      awaited_results [$];
    t_list_result      want;
    int                fail_total;

    task automatic refill_list(input int n);
        for (int k = 0; k < SIZE; k++) begin
            list_order[k] = ELEM_W'(k + 1);
        end
        list_len = n;
    endtask

    task automatic push_result(input logic [ELEM_W-1:0] element, input logic last,
                               input logic status);
        t_list_result r;
        r.element = element;
        r.last    = last;
        r.status  = status;
        awaited_results.push_back(r);
    endtask

    task automatic apply_request(input t_func f, input logic [ID_W-1:0] id);
        int pos;
        pos = -1;
        case (f)
            FN_READ: begin
                for (int k = 0; k < list_len; k++) begin
                    push_result(list_order[k], (k == list_len - 1), 1'b0);
                end
            end
            FN_RESTART: begin
                if (count_reg == 0) refill_list(1);
                else if (count_reg > SIZE) refill_list(SIZE);
                else refill_list(int'(count_reg));
                push_result('0, 1'b1, 1'b0);
            end
            default: begin
                for (int k = 0; k < list_len; k++) begin
                    if (pos < 0 && {3'b000, list_order[k]} == id) pos = k;
                end
                if (pos < 0) begin
                    push_result('0, 1'b1, 1'b1);
                end else begin
                    if (f == FN_FRONT) begin
                        for (int k = pos; k > 0; k--) list_order[k] = list_order[k-1];
                        list_order[0] = id[ELEM_W-1:0];
                    end else begin
                        for (int k = pos; k + 1 < list_len; k++) begin
                            list_order[k] = list_order[k+1];
                        end
                        list_order[list_len-1] = id[ELEM_W-1:0];
                    end
                    push_result('0, 1'b1, 1'b0);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [ELEM_W-1:0] expected,
                               input logic [ELEM_W-1:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, expected, actual);
            fail_total++;
        end
    endtask

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg = CNT_W'(16);
            refill_list((SIZE < 16) ? SIZE : 16);
            awaited_results.delete();
        end else begin
            if (i_cfg_we) count_reg = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with none awaited, element %0d last %0d status %0d",
                             $time, i_element, i_last, i_status);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("element", want.element, i_element);
                    check_field("last", ELEM_W'(want.last), ELEM_W'(i_last));
                    check_field("status", ELEM_W'(want.status), ELEM_W'(i_status));
                end
            end
            if (i_in_valid && !i_in_stall) apply_request(t_func'(i_func), i_element_id);
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

// File: bench/move_to_front_back_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_back_list_core_tb
// Drives the list core with directed requests (list ends, absent ids, every
// operation, count clamping) and then bursts of random requests over several
// count settings, with random sender gaps, a patterned receiver stall and
// repeated long receiver hold-offs. The checker predicts and compares; this
// top gives the verdict.
// ----------------------------------------------------------------------------
module move_to_front_back_list_core_tb;
    import mtfbl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CNT_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [FUNC_W-1:0]   i_func;
    logic [ID_W-1:0]     i_element_id;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [ELEM_W-1:0]   o_element;
    logic                o_last;
    logic                o_status;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles;
    int                  burst_left;
    int                  stim_len;
    int                  next_len;

    move_to_front_back_list_core #(.SIZE(16)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_element_id (i_element_id),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_element    (o_element),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    move_to_front_back_list_chk #(.SIZE(16)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_element_id (i_element_id),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_element    (o_element),
        .i_last       (o_last),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int seg_len;
        int seg_pct;
        int seg_total;
        i_out_stall = 1'b0;
        seg_total = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            seg_total++;
            if (seg_total % 10 == 3) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                seg_len = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0: seg_pct = 0;
                    1: seg_pct = 50;
                    default: seg_pct = 80;
                endcase
                repeat (seg_len) begin
                    @(negedge i_clk);
                    i_out_stall <= ($urandom_range(0, 99) < seg_pct);
                end
            end
        end
    end

    task automatic send_request(input t_func f, input logic [ID_W-1:0] id);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        if (f == FN_RESTART) stim_len = next_len;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_func       <= f;
        i_element_id <= id;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        next_len = (v == 0) ? 1 : (v > 16) ? 16 : int'(v);
    endtask

    task automatic run_random(input int n);
        int roll;
        logic [ID_W-1:0] id;
        t_func f;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) id = $urandom_range(1, stim_len);
            else if (roll < 90) id = $urandom_range(stim_len + 1, 31);
            else id = $urandom_range(0, 255);
            roll = $urandom_range(0, 99);
            if (roll < 42) f = FN_FRONT;
            else if (roll < 80) f = FN_BACK;
            else if (roll < 92) f = FN_READ;
            else f = FN_RESTART;
            send_request(f, id);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_func       = FN_FRONT;
        i_element_id = '0;
        burst_left   = 0;
        stim_len     = 16;
        next_len     = 16;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(FN_READ, 8'd0);
        send_request(FN_FRONT, 8'd1);
        send_request(FN_BACK, 8'd16);
        send_request(FN_FRONT, 8'd16);
        send_request(FN_BACK, 8'd1);
        send_request(FN_FRONT, 8'd0);
        send_request(FN_FRONT, 8'd17);
        send_request(FN_BACK, 8'd255);
        send_request(FN_FRONT, 8'd8);
        send_request(FN_BACK, 8'd8);
        send_request(FN_READ, 8'd255);
        send_request(FN_RESTART, 8'd255);
        send_request(FN_READ, 8'd0);

        write_count(5'd1);
        send_request(FN_RESTART, 8'd0);
        send_request(FN_READ, 8'd0);
        send_request(FN_FRONT, 8'd1);
        send_request(FN_BACK, 8'd1);
        send_request(FN_BACK, 8'd2);
        send_request(FN_FRONT, 8'd16);
        send_request(FN_READ, 8'd0);

        write_count(5'd31);
        send_request(FN_RESTART, 8'd0);
        send_request(FN_READ, 8'd0);
        run_random(45);

        write_count(5'd0);
        send_request(FN_RESTART, 8'd0);
        send_request(FN_READ, 8'd0);
        run_random(30);

        write_count(5'd5);
        send_request(FN_RESTART, 8'd0);
        run_random(50);

        write_count(5'd16);
        send_request(FN_RESTART, 8'd0);
        run_random(60);

        write_count(CNT_W'($urandom_range(2, 15)));
        send_request(FN_RESTART, 8'd0);
        run_random(50);

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
